// ----- src/olist_pkg.sv -----
package olist_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned PosW  = 5;
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_INSERT     = 3'd1,
    MODE_APPEND     = 3'd2,
    MODE_REMOVE     = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_e;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
    logic     live;
  } cell_ctrl_t;

  function automatic logic [IdxW-1:0] first_set(input logic [Depth-1:0] vec);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int k = Depth - 1; k >= 0; k--) begin
      if (vec[k]) begin
        idx = IdxW'(k);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/olist_cell.sv -----
module olist_cell (
  input  logic                           clk_i,
  input  olist_pkg::cell_ctrl_t          ctrl_i,
  input  logic [olist_pkg::DataW-1:0]    new_i,
  input  logic [olist_pkg::DataW-1:0]    key_i,
  input  logic [olist_pkg::DataW-1:0]    left_i,
  input  logic [olist_pkg::DataW-1:0]    right_i,
  output logic [olist_pkg::DataW-1:0]    data_o,
  output logic                           match_o
);
  import olist_pkg::*;

  logic [DataW-1:0] data_q;
  logic             match_q;

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_LOAD:       data_q <= new_i;
      CELL_FROM_LEFT:  data_q <= left_i;
      CELL_FROM_RIGHT: data_q <= right_i;
      default:         data_q <= data_q;
    endcase
    if (ctrl_i.cmp_en) begin
      match_q <= ctrl_i.live && (data_q == key_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

// ----- src/ordered_list_engine_unit.sv -----
// Channel   Handshake          Payload
// request   start / busy       mode_i, value_i, position_i
// result    valid_o (strobe)   status_o, match_index_o, count_o
//
// Each transaction: the accept edge registers the request and every cell
// compares its entry with the value; in S_EXEC the cell chain shifts by one
// place and the result is registered, shown for one cycle on valid_o.
// busy is high for one cycle, in S_EXEC; a new request is accepted only
// while busy is low. Reset clears the entry count; cell contents are not reset.
// The receiver cannot stall the result.
module ordered_list_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   mode_i,
  input  logic signed [31:0]           value_i,
  input  logic [olist_pkg::PosW-1:0]   position_i,
  output logic                         valid_o,
  output logic [1:0]                   status_o,
  output logic [3:0]                   match_index_o,
  output logic [4:0]                   count_o
);
  import olist_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e           state_q;
  logic [2:0]       mode_q;
  logic [DataW-1:0] value_q;
  logic [PosW-1:0]  pos_q;
  logic [CntW-1:0]  count_q;
  logic             valid_q;
  logic [1:0]       status_q;
  logic [IdxW-1:0]  index_q;

  logic             accept;
  logic [DataW-1:0] cell_data [Depth];
  logic [Depth-1:0] match_vec;
  cell_ctrl_t       ctrl [Depth];

  logic             found;
  logic [IdxW-1:0]  first_idx;
  logic             full;
  logic             ins_go;
  logic             rem_go;
  logic [CmpW-1:0]  target;
  logic [CmpW-1:0]  pos_idx;
  logic [CmpW-1:0]  count_ext;
  logic [1:0]       status_d;
  logic [IdxW-1:0]  index_d;
  logic [CntW-1:0]  count_d;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q == S_EXEC);

  assign found     = |match_vec;
  assign first_idx = first_set(match_vec);
  assign full      = (count_q == CntW'(Depth));
  assign count_ext = CmpW'(count_q);
  assign pos_idx   = (pos_q <= PosW'(1)) ? '0 : CmpW'(pos_q - PosW'(1));

  always_comb begin
    ins_go   = 1'b0;
    rem_go   = 1'b0;
    target   = '0;
    status_d = STAT_OK;
    index_d  = '0;
    count_d  = count_q;
    unique case (mode_e'(mode_q))
      MODE_PUSH_FRONT, MODE_INSERT, MODE_APPEND: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          ins_go  = 1'b1;
          count_d = count_q + CntW'(1);
          if (mode_e'(mode_q) == MODE_APPEND) begin
            target = count_ext;
          end else if (mode_e'(mode_q) == MODE_INSERT) begin
            target = (pos_idx > count_ext) ? count_ext : pos_idx;
          end
        end
      end
      MODE_REMOVE, MODE_SEARCH: begin
        if (found) begin
          index_d = first_idx;
          if (mode_e'(mode_q) == MODE_REMOVE) begin
            rem_go  = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end else begin
          status_d = STAT_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left_data;
    logic [DataW-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    always_comb begin
      ctrl[i].op     = CELL_HOLD;
      ctrl[i].cmp_en = accept;
      ctrl[i].live   = (CntW'(i) < count_q);
      if (busy && ins_go) begin
        if (CmpW'(i) == target) begin
          ctrl[i].op = CELL_LOAD;
        end else if ((CmpW'(i) > target) && (CmpW'(i) <= count_ext)) begin
          ctrl[i].op = CELL_FROM_LEFT;
        end
      end else if (busy && rem_go) begin
        if ((CmpW'(i) >= CmpW'(first_idx)) && (CmpW'(i) + CmpW'(1) < count_ext)) begin
          ctrl[i].op = CELL_FROM_RIGHT;
        end
      end
    end

    olist_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .new_i   (value_q),
      .key_i   (value_i),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[i]),
      .match_o (match_vec[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= STAT_OK;
      index_q  <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q  <= S_IDLE;
          count_q  <= count_d;
          valid_q  <= 1'b1;
          status_q <= status_d;
          index_q  <= index_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign match_index_o = 4'(index_q);
  assign count_o       = 5'(count_q);

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> valid_o)
    else $error("transaction finished without a result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a transaction");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count beyond list depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == STAT_FULL)) |-> (count_q == CntW'(Depth)))
    else $error("full status with room left in the list");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import olist_pkg::*;

  localparam int unsigned RandItems  = 980;
  localparam int unsigned StallLimit = 500;
  localparam int unsigned NumRows    = 28;

  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID   = 3'd6;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] match;
    logic [4:0] count;
  } outcome_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [31:0]     value;
    logic [PosW-1:0] pos;
    logic            fixed;
    outcome_t        outcome;
  } plan_row_t;

  localparam outcome_t NoOutcome = '{STAT_OK, 4'd0, 5'd0};

  localparam plan_row_t Plan [NumRows] = '{
    '{MODE_SEARCH,       32'h0000_0000, 5'd0,  1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd0}},
    '{MODE_REMOVE,       32'h1234_5678, 5'd0,  1'b1, '{STAT_NOT_FOUND, 4'd0, 5'd0}},
    '{MODE_UNUSED_FIRST, 32'h0000_0000, 5'd0,  1'b1, '{STAT_OK,        4'd0, 5'd0}},
    '{MODE_PUSH_FRONT,   32'h7FFF_FFFF, 5'd0,  1'b1, '{STAT_OK,        4'd0, 5'd1}},
    '{MODE_APPEND,       32'h8000_0000, 5'd31, 1'b1, '{STAT_OK,        4'd0, 5'd2}},
    '{MODE_INSERT,       32'hFFFF_FFFF, 5'd0,  1'b1, '{STAT_OK,        4'd0, 5'd3}},
    '{MODE_INSERT,       32'h0000_0000, 5'd1,  1'b1, '{STAT_OK,        4'd0, 5'd4}},
    '{MODE_INSERT,       32'h5555_5555, 5'd31, 1'b1, '{STAT_OK,        4'd0, 5'd5}},
    '{MODE_INSERT,       32'hAAAA_AAAA, 5'd16, 1'b1, '{STAT_OK,        4'd0, 5'd6}},
    '{MODE_INSERT,       32'h0000_0001, 5'd3,  1'b0, NoOutcome},
    '{MODE_SEARCH,       32'h8000_0000, 5'd0,  1'b0, NoOutcome},
    '{MODE_UNUSED_MID,   32'hFFFF_FFFF, 5'd31, 1'b0, NoOutcome},
    '{MODE_PUSH_FRONT,   32'h7FFF_FFFF, 5'd0,  1'b0, NoOutcome},
    '{MODE_APPEND,       32'h0000_0001, 5'd0,  1'b0, NoOutcome},
    '{MODE_INSERT,       32'hDEAD_BEEF, 5'd8,  1'b0, NoOutcome},
    '{MODE_PUSH_FRONT,   32'h0000_0002, 5'd0,  1'b0, NoOutcome},
    '{MODE_APPEND,       32'h0000_0003, 5'd0,  1'b0, NoOutcome},
    '{MODE_INSERT,       32'h0000_0004, 5'd15, 1'b0, NoOutcome},
    '{MODE_PUSH_FRONT,   32'h0000_0005, 5'd0,  1'b0, NoOutcome},
    '{MODE_APPEND,       32'h0000_0006, 5'd0,  1'b0, NoOutcome},
    '{MODE_INSERT,       32'h0000_0007, 5'd2,  1'b0, NoOutcome},
    '{MODE_PUSH_FRONT,   32'h0000_0008, 5'd0,  1'b1, '{STAT_FULL,      4'd0, 5'd16}},
    '{MODE_INSERT,       32'h0000_0009, 5'd0,  1'b1, '{STAT_FULL,      4'd0, 5'd16}},
    '{MODE_APPEND,       32'h0000_000A, 5'd31, 1'b1, '{STAT_FULL,      4'd0, 5'd16}},
    '{MODE_SEARCH,       32'h0000_0006, 5'd0,  1'b0, NoOutcome},
    '{MODE_REMOVE,       32'h7FFF_FFFF, 5'd0,  1'b0, NoOutcome},
    '{MODE_SEARCH,       32'hDEAD_BEEF, 5'd0,  1'b0, NoOutcome},
    '{MODE_REMOVE,       32'h8000_0000, 5'd0,  1'b0, NoOutcome}
  };

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   start      = 1'b0;
  logic                   busy;
  logic [2:0]             mode_i     = MODE_PUSH_FRONT;
  logic signed [31:0]     value_i    = '0;
  logic [PosW-1:0]        position_i = '0;
  logic                   valid_o;
  logic [1:0]             status_o;
  logic [3:0]             match_index_o;
  logic [4:0]             count_o;

  logic [31:0] shadow_list [Depth];
  int          shadow_count;
  outcome_t    pending_outcomes [$];
  int          errors = 0;
  int unsigned quiet_cycles = 0;
  bit          allow_idle;

  ordered_list_engine_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .match_index_o (match_index_o),
    .count_o       (count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic predict_outcome(input logic [2:0] mode, input logic [31:0] value,
                                 input logic [PosW-1:0] pos, output outcome_t res);
    int idx;
    int hit;
    res = NoOutcome;
    hit = -1;
    case (mode)
      MODE_PUSH_FRONT, MODE_INSERT, MODE_APPEND: begin
        if (shadow_count >= Depth) begin
          res.status = STAT_FULL;
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            idx = 0;
          end else if (mode == MODE_APPEND) begin
            idx = shadow_count;
          end else begin
            idx = (pos <= 1) ? 0 : int'(pos) - 1;
            if (idx > shadow_count) idx = shadow_count;
          end
          for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = value;
          shadow_count++;
        end
      end
      MODE_REMOVE, MODE_SEARCH: begin
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_list[i] == value) hit = i;
        end
        if (hit < 0) begin
          res.status = STAT_NOT_FOUND;
        end else begin
          res.match = hit[3:0];
          if (mode == MODE_REMOVE) begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = shadow_count[4:0];
  endtask

  // start stays high across back-to-back transactions; lowered only for a gap
  task automatic issue(input logic [2:0] mode, input logic [31:0] value,
                       input logic [PosW-1:0] pos, input logic fixed,
                       input outcome_t fixed_out);
    outcome_t res;
    int gap;
    gap = (allow_idle && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    predict_outcome(mode, value, pos, res);
    pending_outcomes.push_back(fixed ? fixed_out : res);
  endtask

  always @(posedge clk_i) begin
    outcome_t exp_out;
    if (rst_ni && valid_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d match_index %0d count %0d",
               status_o, match_index_o, count_o);
        errors++;
      end else begin
        exp_out = pending_outcomes.pop_front();
        if (status_o !== exp_out.status) begin
          $error("status: expected %0d, actual %0d", exp_out.status, status_o);
          errors++;
        end
        if (match_index_o !== exp_out.match) begin
          $error("match_index: expected %0d, actual %0d", exp_out.match, match_index_o);
          errors++;
        end
        if (count_o !== exp_out.count) begin
          $error("count: expected %0d, actual %0d", exp_out.count, count_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("** ordered_list_engine_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned useful;
    int unsigned calm_from;
    int unsigned next_phase;
    int unsigned grow_pct;
    logic [2:0]  mode;
    logic [31:0] value;
    logic [PosW-1:0] pos;

    shadow_count = 0;
    allow_idle   = 1'b1;
    foreach (shadow_list[i]) shadow_list[i] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      issue(Plan[r].mode, Plan[r].value, Plan[r].pos, Plan[r].fixed, Plan[r].outcome);
    end

    useful     = 0;
    next_phase = 0;
    grow_pct   = 50;
    calm_from  = $urandom_range(300, 600);
    while (useful < RandItems) begin
      if (useful >= next_phase) begin
        grow_pct   = $urandom_range(15, 85);
        next_phase = useful + $urandom_range(30, 80);
      end
      allow_idle = !(useful >= calm_from && useful < calm_from + 150);

      pos = $urandom_range(0, (1 << PosW) - 1);
      if ($urandom_range(0, 99) < 4) begin
        mode  = $urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST);
        value = $urandom();
      end else begin
        useful++;
        if ($urandom_range(0, 99) < grow_pct) begin
          mode = $urandom_range(MODE_PUSH_FRONT, MODE_APPEND);
          case ($urandom_range(0, 3))
            0:       value = $urandom_range(0, 7);
            1:       value = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: value = $urandom();
          endcase
        end else begin
          mode = $urandom_range(0, 1) ? MODE_REMOVE : MODE_SEARCH;
          if (shadow_count > 0 && $urandom_range(0, 99) < 65) begin
            value = shadow_list[$urandom_range(0, shadow_count - 1)];
          end else if ($urandom_range(0, 1)) begin
            value = $urandom_range(0, 7);
          end else begin
            value = $urandom();
          end
        end
      end
      issue(mode, value, pos, 1'b0, NoOutcome);
    end

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("** ordered_list_engine_unit: PASSED **");
    end else begin
      $display("** ordered_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
